/* rtl/core/lpbd_pkg.sv */
`default_nettype none

package lpbd_pkg;

   // field widths fixed by the stream format
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned SEQ_BITS   = 16;
   localparam int unsigned LEN_BITS   = 16;
   localparam int unsigned COUNT_BITS = 8;

   // a length header is two bytes, high byte first
   localparam int unsigned HDR_BYTES  = 2;

   // input tdata layout, lowest bit first
   localparam int unsigned REQ_DATA_BITS = 48;
   localparam int unsigned REQ_BYTE_LSB  = 0;
   localparam int unsigned REQ_PLEN_LSB  = 8;
   localparam int unsigned REQ_COUNT_LSB = 24;
   localparam int unsigned REQ_BASE_LSB  = 32;

   // result tdata and tuser layout, lowest bit first
   localparam int unsigned RSP_DATA_BITS = 56;
   localparam int unsigned RSP_USER_BITS = 2;

   // header parser phases
   typedef enum logic [3:0] {
      PH_HIGH = 4'b0001,
      PH_LOW  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   // one result transaction
   typedef struct packed {
      logic                  byte_valid;
      logic [BYTE_BITS-1:0]  byte_out;
      logic [SEQ_BITS-1:0]   frame_sequence;
      logic [LEN_BITS-1:0]   frame_length;
      logic                  frame_end;
      logic                  packet_end;
      logic [LEN_BITS-1:0]   consumed_bytes;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/lpbd_parser.sv */
`default_nettype none

module lpbd_parser #(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic [lpbd_pkg::BYTE_BITS-1:0]     data_byte,
   input  wire logic [lpbd_pkg::LEN_BITS-1:0]      packet_length,
   input  wire logic [lpbd_pkg::COUNT_BITS-1:0]    frames_in_packet,
   input  wire logic [lpbd_pkg::SEQ_BITS-1:0]      base_sequence,
   output lpbd_pkg::result_type                    result
);

   localparam int unsigned LB = LENGTH_BITS;

   // packet and parser state
   logic [LB-1:0]                      pos_ff, pos_in;
   logic [LB-1:0]                      len_ff, len_in;
   logic [lpbd_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic [lpbd_pkg::SEQ_BITS-1:0]      base_ff, base_in;
   logic [lpbd_pkg::COUNT_BITS-1:0]    index_ff, index_in;
   lpbd_pkg::phase_type                phase_ff, phase_in;
   logic [lpbd_pkg::BYTE_BITS-1:0]     hi_ff, hi_in;
   logic [LB-1:0]                      cur_len_ff, cur_len_in;
   logic [LB-1:0]                      left_ff, left_in;
   logic [LB-1:0]                      consumed_ff, consumed_in;

   // values seen by this byte: fresh ones at the first byte of a packet
   logic                               first;
   logic [LB-1:0]                      plen_masked;
   logic [LB-1:0]                      eff_len;
   logic [lpbd_pkg::COUNT_BITS-1:0]    eff_count;
   logic [lpbd_pkg::SEQ_BITS-1:0]      eff_base;
   logic [lpbd_pkg::COUNT_BITS-1:0]    eff_index;
   lpbd_pkg::phase_type                eff_phase;
   logic [lpbd_pkg::BYTE_BITS-1:0]     eff_hi;
   logic [LB-1:0]                      eff_cur_len;
   logic [LB-1:0]                      eff_left;
   logic [LB-1:0]                      eff_consumed;

   logic [LB-1:0]                      next_pos;
   logic                               pend;
   logic                               hdr_fits;
   logic [2*lpbd_pkg::BYTE_BITS-1:0]   hdr_word;
   logic [LB-1:0]                      hdr_len;
   logic                               hdr_bad;
   logic [LB-1:0]                      left_dec;

   assign first       = (pos_ff == '0);
   assign plen_masked = packet_length[LB-1:0];

   always_comb begin
      if (first) begin
         eff_len      = (plen_masked == '0) ? LB'(1) : plen_masked;
         eff_count    = frames_in_packet;
         eff_base     = base_sequence;
         eff_index    = '0;
         eff_phase    = lpbd_pkg::PH_HIGH;
         eff_hi       = '0;
         eff_cur_len  = '0;
         eff_left     = '0;
         eff_consumed = '0;
      end else begin
         eff_len      = len_ff;
         eff_count    = count_ff;
         eff_base     = base_ff;
         eff_index    = index_ff;
         eff_phase    = phase_ff;
         eff_hi       = hi_ff;
         eff_cur_len  = cur_len_ff;
         eff_left     = left_ff;
         eff_consumed = consumed_ff;
      end
   end

   // position and header checks
   assign next_pos = pos_ff + LB'(1);
   assign pend     = (next_pos >= eff_len);
   assign hdr_fits = ({1'b0, pos_ff} + (LB+1)'(lpbd_pkg::HDR_BYTES)) <= {1'b0, eff_len};
   assign hdr_word = {eff_hi, data_byte};
   assign hdr_len  = hdr_word[LB-1:0];
   assign hdr_bad  = (hdr_len == '0) ||
                     (({1'b0, next_pos} + {1'b0, hdr_len}) > {1'b0, eff_len});
   assign left_dec = eff_left - LB'(1);

   // per-byte step
   always_comb begin
      len_in      = eff_len;
      count_in    = eff_count;
      base_in     = eff_base;
      index_in    = eff_index;
      phase_in    = eff_phase;
      hi_in       = eff_hi;
      cur_len_in  = eff_cur_len;
      left_in     = eff_left;
      consumed_in = eff_consumed;
      pos_in      = pend ? '0 : next_pos;

      result                = '0;
      result.packet_end     = pend;

      if (eff_count <= lpbd_pkg::COUNT_BITS'(1)) begin
         // whole payload is one frame
         result.byte_valid     = 1'b1;
         result.frame_sequence = eff_base;
         result.frame_length   = lpbd_pkg::LEN_BITS'(eff_len);
         result.frame_end      = pend;
         consumed_in           = next_pos;
      end else begin
         unique case (eff_phase)
            lpbd_pkg::PH_HIGH: begin
               if ((eff_index < eff_count) && hdr_fits) begin
                  hi_in       = data_byte;
                  consumed_in = next_pos;
                  phase_in    = lpbd_pkg::PH_LOW;
               end else begin
                  phase_in = lpbd_pkg::PH_DONE;
               end
            end
            lpbd_pkg::PH_LOW: begin
               consumed_in = next_pos;
               if (hdr_bad) begin
                  // skipped frame still uses up its index
                  index_in = eff_index + lpbd_pkg::COUNT_BITS'(1);
                  phase_in = lpbd_pkg::PH_HIGH;
               end else begin
                  cur_len_in = hdr_len;
                  left_in    = hdr_len;
                  phase_in   = lpbd_pkg::PH_BODY;
               end
            end
            lpbd_pkg::PH_BODY: begin
               result.byte_valid     = 1'b1;
               result.frame_sequence = eff_base + lpbd_pkg::SEQ_BITS'(eff_index);
               result.frame_length   = lpbd_pkg::LEN_BITS'(eff_cur_len);
               consumed_in           = next_pos;
               left_in               = left_dec;
               if (left_dec == '0) begin
                  result.frame_end = 1'b1;
                  index_in         = eff_index + lpbd_pkg::COUNT_BITS'(1);
                  phase_in         = lpbd_pkg::PH_HIGH;
               end
            end
            lpbd_pkg::PH_DONE: begin
               phase_in = lpbd_pkg::PH_DONE;
            end
            default: begin
               phase_in = lpbd_pkg::PH_DONE;
            end
         endcase
      end

      if (result.byte_valid) begin
         result.byte_out = data_byte;
      end
      if (pend) begin
         result.consumed_bytes = lpbd_pkg::LEN_BITS'(consumed_in);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= lpbd_pkg::PH_HIGH;
         index_ff <= '0;
         count_ff <= '0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         index_ff <= index_in;
         count_ff <= count_in;
      end
   end

   // packet fields and counters, loaded fresh at each packet start
   always_ff @(posedge clock) begin
      if (advance) begin
         len_ff      <= len_in;
         base_ff     <= base_in;
         hi_ff       <= hi_in;
         cur_len_ff  <= cur_len_in;
         left_ff     <= left_in;
         consumed_ff <= consumed_in;
      end
   end

   // a packet end always returns to the packet start
   assert property (@(posedge clock) disable iff (reset)
      advance && result.packet_end |=> pos_ff == '0)
      else $error("position not cleared after packet end");

   // a frame end only marks a delivered byte
   assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_end |-> result.byte_valid)
      else $error("frame end on an undelivered byte");

   // in batch mode bytes are only delivered from a frame body
   assert property (@(posedge clock) disable iff (reset)
      advance && !first && (count_ff > lpbd_pkg::COUNT_BITS'(1)) && result.byte_valid
      |-> phase_ff == lpbd_pkg::PH_BODY)
      else $error("byte delivered outside a frame body");

   // consumed count never runs past the packet length
   assert property (@(posedge clock) disable iff (reset)
      advance && result.packet_end
      |-> result.consumed_bytes <= lpbd_pkg::LEN_BITS'(eff_len))
      else $error("consumed count beyond packet length");

endmodule

`default_nettype wire

/* rtl/core/length_prefixed_batch_deframer.sv */
// Length-prefixed batch deframer.
// The req channel carries one payload byte per transaction together with the
// packet length, batched frame count and base sequence; the last three are
// only looked at on the first byte of each packet. The rsp channel returns
// exactly one transaction per input byte, in order: tuser flags whether the
// byte belongs to a delivered frame and whether it ends that frame, tlast
// marks the last byte of the packet, and tdata carries the byte, the frame
// sequence (base plus frame index), the frame length and, on the packet's
// last byte, the count of bytes consumed by parsing.
// An accepted byte waits in the input register, then the header parser
// processes it into the result register, from which rsp shows it. Throughput
// is one byte per cycle while the receiver does not stall, set by the
// combinational header parser between the input register and the result
// register; the parser state advances once per byte.
// Reset clears both registers' valid flags and puts the parser at the start
// of a packet. When the receiver stalls, the result register holds, the input
// register takes one more byte, and req_tready then drops until rsp moves.
`default_nettype none

module length_prefixed_batch_deframer #(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // data_byte, packet_length, frames_in_packet, base_sequence
   input  wire logic [lpbd_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // byte_out, frame_sequence, frame_length, consumed_bytes
   output      logic [lpbd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // byte_valid, frame_end
   output      logic [lpbd_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   // packet_end
   output      logic                                 rsp_tlast
);

   logic                                  in_valid_ff;
   logic [lpbd_pkg::REQ_DATA_BITS-1:0]    in_data_ff;
   logic                                  out_valid_ff;
   lpbd_pkg::result_type                  out_ff;
   lpbd_pkg::result_type                  step_result;
   logic                                  advance;

   // move a byte from the input register to the result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   lpbd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .data_byte        (in_data_ff[lpbd_pkg::REQ_BYTE_LSB +: lpbd_pkg::BYTE_BITS]),
      .packet_length    (in_data_ff[lpbd_pkg::REQ_PLEN_LSB +: lpbd_pkg::LEN_BITS]),
      .frames_in_packet (in_data_ff[lpbd_pkg::REQ_COUNT_LSB +: lpbd_pkg::COUNT_BITS]),
      .base_sequence    (in_data_ff[lpbd_pkg::REQ_BASE_LSB +: lpbd_pkg::SEQ_BITS]),
      .result           (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   // result packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.consumed_bytes, out_ff.frame_length,
                        out_ff.frame_sequence, out_ff.byte_out};
   assign rsp_tuser  = {out_ff.frame_end, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.packet_end;

endmodule

`default_nettype wire
